/* rtl/fpa_pkg.sv */
package fpa_pkg;

	// Placement policy codes held in the fit_policy register
	localparam logic [1:0] POLICY_FIRST = 2'd0;
	localparam logic [1:0] POLICY_BEST  = 2'd1;
	localparam logic [1:0] POLICY_WORST = 2'd2;

	// Item modes
	localparam logic MODE_LOAD  = 1'b0;
	localparam logic MODE_ALLOC = 1'b1;

	// Configuration register indexes
	localparam logic REG_FIT_POLICY      = 1'b0;
	localparam logic REG_PARTITION_COUNT = 1'b1;

	// Field widths fixed by the interface
	localparam int POLICY_W   = 2;
	localparam int COUNT_W    = 6;
	localparam int CFG_DATA_W = 6;
	localparam int PIDX_W     = 5;
	localparam int SIZE_W     = 16;

	// Control from the scan sequencer to the fit unit
	typedef struct packed {
		logic       clear;
		logic       eval_en;
		logic [1:0] policy;
	} fit_ctl_t;

endpackage

/* rtl/fixed_partition_fit_allocator.sv */
// Fixed-partition allocator. A load item (mode 0) writes one partition's size and marks it
// free and returns nothing. An allocate item (mode 1) scans partitions
// 0 .. min(partition_count, NUM_PARTITIONS)-1 through the partition table, one read per
// cycle, and picks a free partition that holds the request by the fit_policy register:
// first fit (lowest index, also for code 3), best fit (least leftover) or worst fit (most
// leftover), ties going to the lower index. The pick is marked used and one result item
// returns found, the index and the leftover; when nothing fits, found, index and leftover
// are all zero and the table is left alone. An allocation occupies the block from accept
// through the table reads, one per entry up to the limit, and the registered read to the
// write-back; with a count of zero no read is made, and first fit stops at its first hit.
// The table read port sets the length of the scan. Input is taken only while no
// allocation is in flight; a finished result waits in the output register while loads and
// the next allocation proceed, and the write-back holds only if that register is still
// full. Used bits live in the table beside the sizes: every load to an index below
// NUM_PARTITIONS clears its entry's used bit, and an entry that was never loaded must not
// be scanned, so the table needs no clearing pass after reset.
module fixed_partition_fit_allocator #(
	parameter int NUM_PARTITIONS = 32,
	parameter int SIZE_BITS      = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic                               cfg_addr,
	input  logic [fpa_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               mode,
	input  logic [fpa_pkg::PIDX_W-1:0]         partition_index,
	input  logic [fpa_pkg::SIZE_W-1:0]         size_value,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic                               found,
	output logic [fpa_pkg::PIDX_W-1:0]         chosen_partition,
	output logic [fpa_pkg::SIZE_W-1:0]         leftover
);

	localparam int IDX_W   = (NUM_PARTITIONS > 1) ? $clog2(NUM_PARTITIONS) : 1;
	localparam int LIM_W   = $clog2(NUM_PARTITIONS + 1);
	localparam int ENTRY_W = SIZE_BITS + 1;

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_SCAN   = 2'd1;
	localparam logic [1:0] S_FINISH = 2'd2;

	logic [1:0] state_q;

	// Configuration registers
	logic [fpa_pkg::POLICY_W-1:0] fit_policy_q;
	logic [fpa_pkg::COUNT_W-1:0]  partition_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_policy_q      <= fpa_pkg::POLICY_FIRST;
			partition_count_q <= '0;
		end else if (cfg_we) begin
			case (cfg_addr)
				fpa_pkg::REG_FIT_POLICY:      fit_policy_q <= cfg_data[fpa_pkg::POLICY_W-1:0];
				fpa_pkg::REG_PARTITION_COUNT: partition_count_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input decode
	logic                 in_acc;
	logic [31:0]          pidx_ext;
	logic [31:0]          size_ext;
	logic [SIZE_BITS-1:0] size_in;
	logic                 load_ok;
	logic [LIM_W-1:0]     limit_in;

	assign in_ready = (state_q == S_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign pidx_ext = 32'(partition_index);
	assign size_ext = 32'(size_value);
	assign size_in  = size_ext[SIZE_BITS-1:0];
	assign load_ok  = (pidx_ext < NUM_PARTITIONS);
	assign limit_in = (32'(partition_count_q) > NUM_PARTITIONS) ?
		LIM_W'(NUM_PARTITIONS) : LIM_W'(partition_count_q);

	// Per-allocation registers
	logic [SIZE_BITS-1:0]         req_q;
	logic [fpa_pkg::POLICY_W-1:0] policy_q;
	logic [LIM_W-1:0]             limit_q;
	logic [LIM_W-1:0]             cnt_q;
	logic                         rvld_s1;
	logic [IDX_W-1:0]             ridx_s1;

	always_ff @(posedge clk) begin
		if (in_acc && (mode == fpa_pkg::MODE_ALLOC)) begin
			req_q    <= size_in;
			policy_q <= fit_policy_q;
			limit_q  <= limit_in;
		end
	end

	// Partition table: {used, size}, one write and one registered read per cycle
	logic [ENTRY_W-1:0] table_mem [NUM_PARTITIONS];
	logic               mem_we;
	logic [IDX_W-1:0]   mem_waddr;
	logic [ENTRY_W-1:0] mem_wdata;
	logic               mem_re;
	logic [ENTRY_W-1:0] rdata_s1;

	// Fit unit
	fpa_pkg::fit_ctl_t    fit_ctl;
	logic                 fit_have;
	logic [IDX_W-1:0]     fit_pick;
	logic [SIZE_BITS-1:0] fit_best;
	logic [SIZE_BITS-1:0] fit_pick_size;
	logic                 fit_first_hit;
	logic                 last_eval;
	logic                 slot_free;

	assign mem_re    = (state_q == S_SCAN) && (cnt_q < limit_q);
	assign last_eval = (32'(ridx_s1) + 32'd1 == 32'(limit_q));
	assign slot_free = !out_valid || out_ready;

	always_comb begin
		if (state_q == S_FINISH) begin
			mem_we    = slot_free && fit_have;
			mem_waddr = fit_pick;
			mem_wdata = {1'b1, fit_pick_size};
		end else begin
			mem_we    = in_acc && (mode == fpa_pkg::MODE_LOAD) && load_ok;
			mem_waddr = pidx_ext[IDX_W-1:0];
			mem_wdata = {1'b0, size_in};
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			table_mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_s1 <= table_mem[cnt_q[IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (mem_re) begin
			ridx_s1 <= cnt_q[IDX_W-1:0];
		end
	end

	always_comb begin
		fit_ctl.clear   = in_acc;
		fit_ctl.eval_en = rvld_s1 && (state_q == S_SCAN);
		fit_ctl.policy  = policy_q;
	end

	fpa_fit_unit #(
		.IDX_W     (IDX_W),
		.SIZE_BITS (SIZE_BITS)
	) u_fit (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (fit_ctl),
		.req        (req_q),
		.entry_used (rdata_s1[SIZE_BITS]),
		.entry_size (rdata_s1[SIZE_BITS-1:0]),
		.entry_idx  (ridx_s1),
		.have       (fit_have),
		.pick       (fit_pick),
		.best       (fit_best),
		.pick_size  (fit_pick_size),
		.first_hit  (fit_first_hit)
	);

	// Sequencer: issue reads, stop at the last entry or at a first-fit hit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			rvld_s1 <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					rvld_s1 <= 1'b0;
					cnt_q   <= '0;
					if (in_acc && (mode == fpa_pkg::MODE_ALLOC)) begin
						state_q <= (limit_in == '0) ? S_FINISH : S_SCAN;
					end
				end
				S_SCAN: begin
					if (mem_re) begin
						cnt_q <= cnt_q + LIM_W'(1);
					end
					if (rvld_s1 && (last_eval || fit_first_hit)) begin
						rvld_s1 <= 1'b0;
						state_q <= S_FINISH;
					end else begin
						rvld_s1 <= mem_re;
					end
				end
				S_FINISH: begin
					rvld_s1 <= 1'b0;
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					rvld_s1 <= 1'b0;
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Output register: hold the result until taken
	logic [31:0] pick_ext;
	logic [31:0] best_ext;

	assign pick_ext = 32'(fit_pick);
	assign best_ext = 32'(fit_best);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if ((state_q == S_FINISH) && slot_free) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_FINISH) && slot_free) begin
			found            <= fit_have;
			chosen_partition <= fit_have ? pick_ext[fpa_pkg::PIDX_W-1:0] : '0;
			leftover         <= fit_have ? best_ext[fpa_pkg::SIZE_W-1:0] : '0;
		end
	end

	// Checks
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (cnt_q <= limit_q))
		else $error("scan read counter ran past the limit");

	a_notfound_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !found) |-> ((chosen_partition == '0) && (leftover == '0)))
		else $error("not-found result carries nonzero fields");

	a_alloc_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && (mode == fpa_pkg::MODE_ALLOC)) |=> (state_q != S_IDLE))
		else $error("allocation accepted but sequencer stayed idle");

	a_rvld_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rvld_s1 |-> (state_q == S_SCAN))
		else $error("table read pending outside the scan");

	a_wb_result: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_FINISH) && slot_free) |=> (out_valid && (state_q == S_IDLE)))
		else $error("write-back did not deliver a result");

endmodule

/* rtl/fpa_fit_unit.sv */
module fpa_fit_unit #(
	parameter int IDX_W     = 5,
	parameter int SIZE_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  fpa_pkg::fit_ctl_t    ctl,
	input  logic [SIZE_BITS-1:0] req,
	input  logic                 entry_used,
	input  logic [SIZE_BITS-1:0] entry_size,
	input  logic [IDX_W-1:0]     entry_idx,
	output logic                 have,
	output logic [IDX_W-1:0]     pick,
	output logic [SIZE_BITS-1:0] best,
	output logic [SIZE_BITS-1:0] pick_size,
	output logic                 first_hit
);

	logic                 have_q;
	logic [IDX_W-1:0]     pick_q;
	logic [SIZE_BITS-1:0] best_q;
	logic [SIZE_BITS-1:0] pick_size_q;
	logic                 fits;
	logic [SIZE_BITS-1:0] left;
	logic                 take;
	logic                 is_best;
	logic                 is_worst;

	assign is_best  = (ctl.policy == fpa_pkg::POLICY_BEST);
	assign is_worst = (ctl.policy == fpa_pkg::POLICY_WORST);
	assign fits     = ctl.eval_en && !entry_used && (entry_size >= req);
	assign left     = entry_size - req;

	// Ties keep the lower index: only a strictly better leftover replaces
	always_comb begin
		if (!fits) begin
			take = 1'b0;
		end else if (!have_q) begin
			take = 1'b1;
		end else if (is_best) begin
			take = (left < best_q);
		end else if (is_worst) begin
			take = (left > best_q);
		end else begin
			take = 1'b1;
		end
	end

	assign first_hit = fits && !is_best && !is_worst;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q <= 1'b0;
		end else if (ctl.clear) begin
			have_q <= 1'b0;
		end else if (take) begin
			have_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			pick_q      <= entry_idx;
			best_q      <= left;
			pick_size_q <= entry_size;
		end
	end

	assign have      = have_q;
	assign pick      = pick_q;
	assign best      = best_q;
	assign pick_size = pick_size_q;

endmodule
